/* rtl/blsc_pkg.sv */
package blsc_pkg;

    // Sizes
    localparam int MAX_BLOCKS  = 256;
    localparam int MAX_DIMS    = 8;
    localparam int CW          = 32;
    localparam int BLK_W       = $clog2(MAX_BLOCKS);
    localparam int CNT_W       = BLK_W + 1;
    localparam int DIM_W       = $clog2(MAX_DIMS);
    localparam int NDIM_W      = 4;
    localparam int POS_W       = BLK_W + DIM_W + 1;
    localparam int TOT_W       = CNT_W + NDIM_W;
    localparam int ADDR_W      = 1 + BLK_W + DIM_W;
    localparam int WORD_W      = 2 * CW;
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    // Item function codes
    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_PROC = 2'd1,
        FUNC_READ = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    // Register indexes
    localparam logic [1:0] CFG_NUM_DIMS = 2'd0;
    localparam logic [1:0] CFG_EXT_END  = 2'd1;
    localparam logic [1:0] CFG_PREMERGE = 2'd2;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_SORT,
        PH_POST
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RD_ISSUE,
        S_RD_DATA,
        S_RESULT,
        S_MG_INIT,
        S_MG_J_RD,
        S_MG_J_CAP,
        S_MG_I_CHK,
        S_MG_I_RD,
        S_MG_I_CAP,
        S_MG_DECIDE,
        S_MG_WR,
        S_MG_END,
        S_SR_INIT,
        S_SR_I_RD,
        S_SR_I_CAP,
        S_SR_J_CHK,
        S_SR_J_RD,
        S_SR_J_CAP,
        S_SR_J_EVAL,
        S_SR_WR
    } t_state;

    // Write request to the coordinate store
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } t_wr_req;

    // ceil(2^RECIP_SHIFT / nd), exact floor division for positions below 2^12
    function automatic logic [RECIP_W-1:0] recip(input logic [NDIM_W-1:0] nd);
        logic [RECIP_W-1:0] r;
        begin
            unique case (nd)
                4'd2:    r = RECIP_W'(32768);
                4'd3:    r = RECIP_W'(21846);
                4'd4:    r = RECIP_W'(16384);
                4'd5:    r = RECIP_W'(13108);
                4'd6:    r = RECIP_W'(10923);
                4'd7:    r = RECIP_W'(9363);
                4'd8:    r = RECIP_W'(8192);
                default: r = RECIP_W'(65536);
            endcase
            return r;
        end
    endfunction

endpackage

/* rtl/blsc_store.sv */
module blsc_store (
    input  logic                         i_clk,
    input  blsc_pkg::t_wr_req            i_wr,
    input  logic [blsc_pkg::ADDR_W-1:0]  i_raddr,
    output logic [blsc_pkg::WORD_W-1:0]  o_rdata
);

    // Two banks of rows: {start, extent} per coordinate
    logic [blsc_pkg::WORD_W-1:0] mem [2**blsc_pkg::ADDR_W];
    logic [blsc_pkg::WORD_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/block_list_sort_and_coalesce.sv */
// Channel  | valid       | ready       | payload
// ---------+-------------+-------------+-------------------------------------------
// input    | i_in_valid  | o_in_ready  | i_func, i_start_coord, i_extent
// result   | o_out_valid | i_out_ready | o_out_start .. o_overflow
// config   | i_cfg_valid | o_cfg_ready | i_cfg_index, i_cfg_data
//
// A load is written straight from the idle state; a read goes through the store's read port
// (issue, data and result states). A process walks the store one coordinate at a time, each
// read then captured: a merge pass per dimension, the stable sort a rank count over all row pairs.
// Reset is synchronous and active low; the store itself is not cleared.
// Loads are taken while a result waits; a result holds until transferred.
module block_list_sort_and_coalesce (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_start_coord,
    input  logic [31:0] i_extent,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_out_start,
    output logic [31:0] o_out_extent,
    output logic [2:0]  o_dim_index,
    output logic [7:0]  o_block_index,
    output logic [8:0]  o_block_count,
    output logic        o_last_flag,
    output logic        o_overflow,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);

    localparam int CW     = blsc_pkg::CW;
    localparam int BLK_W  = blsc_pkg::BLK_W;
    localparam int CNT_W  = blsc_pkg::CNT_W;
    localparam int DIM_W  = blsc_pkg::DIM_W;
    localparam int ND     = blsc_pkg::MAX_DIMS;
    localparam int POS_W  = blsc_pkg::POS_W;
    localparam int TOT_W  = blsc_pkg::TOT_W;
    localparam int NDIM_W = blsc_pkg::NDIM_W;

    blsc_pkg::t_state r_state, n_state;
    blsc_pkg::t_phase r_phase, n_phase;

    logic [CNT_W-1:0]  r_n, n_n;
    logic [DIM_W-1:0]  r_load_pos, n_load_pos;
    logic [POS_W-1:0]  r_read_pos, n_read_pos;
    logic              r_ovf, n_ovf;
    logic              r_bank, n_bank;
    logic [NDIM_W-1:0] r_num_dims;
    logic              r_ext_end;
    logic              r_premerge;

    logic [DIM_W-1:0]  r_d, n_d;
    logic [DIM_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_i, n_i;
    logic [CNT_W-1:0]  r_j, n_j;
    logic [BLK_W-1:0]  r_rank, n_rank;
    logic              r_ok, n_ok;
    logic              r_dec, n_dec;
    logic              r_lt, n_lt;
    logic              r_gt, n_gt;
    logic              r_wr_end, n_wr_end;

    logic [CW-1:0] r_cache_s [ND];
    logic [CW-1:0] r_cache_e [ND];
    logic [CW-1:0] r_cur_s   [ND];
    logic [CW-1:0] r_cur_e   [ND];
    logic [CW-1:0] n_cache_s [ND];
    logic [CW-1:0] n_cache_e [ND];
    logic [CW-1:0] n_cur_s   [ND];
    logic [CW-1:0] n_cur_e   [ND];

    logic [CW-1:0]    r_res_s, n_res_s;
    logic [CW-1:0]    r_res_e, n_res_e;
    logic [DIM_W-1:0] r_res_dim, n_res_dim;
    logic [BLK_W-1:0] r_res_blk, n_res_blk;
    logic             r_res_last, n_res_last;
    logic             r_res_proc, n_res_proc;

    logic             r_out_valid, n_out_valid;
    logic [CW-1:0]    r_out_start, n_out_start;
    logic [CW-1:0]    r_out_extent, n_out_extent;
    logic [DIM_W-1:0] r_out_dim, n_out_dim;
    logic [BLK_W-1:0] r_out_blk, n_out_blk;
    logic [CNT_W-1:0] r_out_cnt, n_out_cnt;
    logic             r_out_last, n_out_last;
    logic             r_out_ovf, n_out_ovf;

    blsc_pkg::t_wr_req              wr;
    logic [blsc_pkg::ADDR_W-1:0]    raddr;
    logic [blsc_pkg::WORD_W-1:0]    rdata;
    logic [CW-1:0]                  rd_s, rd_e;

    logic [NDIM_W-1:0]              nd;
    logic [DIM_W-1:0]               ndm1;
    logic                           k_last;
    logic                           in_xfer;
    logic                           slot_free;
    logic [DIM_W-1:0]               lpos;
    logic [TOT_W-1:0]               total;
    logic [POS_W+blsc_pkg::RECIP_W-1:0] prod;
    logic [BLK_W-1:0]               rd_blk;
    logic [DIM_W-1:0]               rd_dim;
    logic                           rd_avail;
    logic [CW-1:0]                  cs, ce, jce, jei;
    logic [CW:0]                    tsum, msum;
    logic                           cond;

    // Coordinate store
    blsc_store u_store (
        .i_clk   (i_clk),
        .i_wr    (wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_s = rdata[2*CW-1:CW];
    assign rd_e = rdata[CW-1:0];

    // Effective dimension count
    always_comb begin
        if (r_num_dims == '0) begin
            nd = NDIM_W'(1);
        end else if (r_num_dims > NDIM_W'(ND)) begin
            nd = NDIM_W'(ND);
        end else begin
            nd = r_num_dims;
        end
    end
    assign ndm1   = DIM_W'(nd - NDIM_W'(1));
    assign k_last = (r_k == ndm1);

    assign o_in_ready  = (r_state == blsc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;

    assign lpos = (r_load_pos > ndm1) ? ndm1 : r_load_pos;

    // Read position split into block and dimension by reciprocal multiply
    assign total    = TOT_W'(r_n) * TOT_W'(nd);
    assign rd_avail = (TOT_W'(r_read_pos) < total);
    assign prod     = (POS_W + blsc_pkg::RECIP_W)'(r_read_pos)
                      * (POS_W + blsc_pkg::RECIP_W)'(blsc_pkg::recip(nd));
    assign rd_blk   = prod[blsc_pkg::RECIP_SHIFT +: BLK_W];
    assign rd_dim   = r_read_pos[DIM_W-1:0] - DIM_W'(rd_blk[DIM_W-1:0] * nd[DIM_W-1:0]);

    // Touch and match test for one coordinate of row i against cached row j
    assign cs   = r_cache_s[r_k];
    assign ce   = r_cache_e[r_k];
    assign tsum = {1'b0, cs} + {1'b0, ce};
    always_comb begin
        if (r_k == r_d) begin
            if (r_ext_end) begin
                cond = (ce != '1) && ((ce + CW'(1)) == rd_s);
            end else begin
                cond = !tsum[CW] && (tsum[CW-1:0] == rd_s);
            end
        end else begin
            cond = (rd_s == cs) && (rd_e == ce);
        end
    end

    // Joined extent along the pass dimension
    assign jce  = r_cache_e[r_d];
    assign jei  = r_cur_e[r_d];
    assign msum = {1'b0, jce} + {1'b0, jei};

    // Store read address
    always_comb begin
        unique case (r_state)
            blsc_pkg::S_RD_ISSUE: raddr = {r_bank, r_res_blk, r_res_dim};
            blsc_pkg::S_MG_J_RD,
            blsc_pkg::S_SR_J_RD:  raddr = {r_bank, r_j[BLK_W-1:0], r_k};
            blsc_pkg::S_MG_I_RD,
            blsc_pkg::S_SR_I_RD:  raddr = {r_bank, r_i[BLK_W-1:0], r_k};
            default:              raddr = '0;
        endcase
    end

    // Store write request
    always_comb begin
        wr.we   = 1'b0;
        wr.addr = '0;
        wr.data = '0;
        unique case (r_state)
            blsc_pkg::S_IDLE: begin
                if (in_xfer && (i_func == blsc_pkg::FUNC_LOAD)
                    && (r_n != CNT_W'(blsc_pkg::MAX_BLOCKS))) begin
                    wr.we   = 1'b1;
                    wr.addr = {r_bank, r_n[BLK_W-1:0], lpos};
                    wr.data = {i_start_coord, i_extent};
                end
            end
            blsc_pkg::S_MG_WR: begin
                wr.we   = 1'b1;
                wr.addr = {r_bank, r_j[BLK_W-1:0], r_k};
                wr.data = {r_cache_s[r_k], r_cache_e[r_k]};
            end
            blsc_pkg::S_SR_WR: begin
                wr.we   = 1'b1;
                wr.addr = {~r_bank, r_rank, r_k};
                wr.data = {r_cache_s[r_k], r_cache_e[r_k]};
            end
            default: begin
                wr.we = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            blsc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    if (i_func == blsc_pkg::FUNC_PROC) begin
                        n_state = r_premerge ? blsc_pkg::S_MG_INIT : blsc_pkg::S_SR_INIT;
                    end else if ((i_func == blsc_pkg::FUNC_READ) && rd_avail) begin
                        n_state = blsc_pkg::S_RD_ISSUE;
                    end
                end
            end
            blsc_pkg::S_RD_ISSUE: n_state = blsc_pkg::S_RD_DATA;
            blsc_pkg::S_RD_DATA:  n_state = blsc_pkg::S_RESULT;
            blsc_pkg::S_RESULT: begin
                if (slot_free) n_state = blsc_pkg::S_IDLE;
            end
            blsc_pkg::S_MG_INIT: begin
                n_state = (r_n == '0) ? blsc_pkg::S_MG_END : blsc_pkg::S_MG_J_RD;
            end
            blsc_pkg::S_MG_J_RD:  n_state = blsc_pkg::S_MG_J_CAP;
            blsc_pkg::S_MG_J_CAP: begin
                n_state = k_last ? blsc_pkg::S_MG_I_CHK : blsc_pkg::S_MG_J_RD;
            end
            blsc_pkg::S_MG_I_CHK: begin
                n_state = (r_i == r_n) ? blsc_pkg::S_MG_WR : blsc_pkg::S_MG_I_RD;
            end
            blsc_pkg::S_MG_I_RD:  n_state = blsc_pkg::S_MG_I_CAP;
            blsc_pkg::S_MG_I_CAP: begin
                n_state = k_last ? blsc_pkg::S_MG_DECIDE : blsc_pkg::S_MG_I_RD;
            end
            blsc_pkg::S_MG_DECIDE: begin
                n_state = r_ok ? blsc_pkg::S_MG_I_CHK : blsc_pkg::S_MG_WR;
            end
            blsc_pkg::S_MG_WR: begin
                if (k_last) begin
                    if (!r_wr_end) begin
                        n_state = blsc_pkg::S_MG_I_CHK;
                    end else if (r_d == '0) begin
                        n_state = blsc_pkg::S_MG_END;
                    end else begin
                        n_state = blsc_pkg::S_MG_INIT;
                    end
                end
            end
            blsc_pkg::S_MG_END: begin
                n_state = (r_phase == blsc_pkg::PH_PRE) ? blsc_pkg::S_SR_INIT
                                                         : blsc_pkg::S_RESULT;
            end
            blsc_pkg::S_SR_INIT: begin
                n_state = (r_n <= CNT_W'(1)) ? blsc_pkg::S_MG_INIT : blsc_pkg::S_SR_I_RD;
            end
            blsc_pkg::S_SR_I_RD:  n_state = blsc_pkg::S_SR_I_CAP;
            blsc_pkg::S_SR_I_CAP: begin
                n_state = k_last ? blsc_pkg::S_SR_J_CHK : blsc_pkg::S_SR_I_RD;
            end
            blsc_pkg::S_SR_J_CHK: begin
                if (r_j == r_n) begin
                    n_state = blsc_pkg::S_SR_WR;
                end else if (r_j != r_i) begin
                    n_state = blsc_pkg::S_SR_J_RD;
                end
            end
            blsc_pkg::S_SR_J_RD:  n_state = blsc_pkg::S_SR_J_CAP;
            blsc_pkg::S_SR_J_CAP: begin
                n_state = k_last ? blsc_pkg::S_SR_J_EVAL : blsc_pkg::S_SR_J_RD;
            end
            blsc_pkg::S_SR_J_EVAL: n_state = blsc_pkg::S_SR_J_CHK;
            blsc_pkg::S_SR_WR: begin
                if (k_last) begin
                    n_state = ((r_i + CNT_W'(1)) == r_n) ? blsc_pkg::S_MG_INIT
                                                          : blsc_pkg::S_SR_I_RD;
                end
            end
            default: n_state = blsc_pkg::S_IDLE;
        endcase
    end

    // Datapath and counters
    always_comb begin
        n_phase    = r_phase;
        n_n        = r_n;
        n_load_pos = r_load_pos;
        n_read_pos = r_read_pos;
        n_ovf      = r_ovf;
        n_bank     = r_bank;
        n_d        = r_d;
        n_k        = r_k;
        n_i        = r_i;
        n_j        = r_j;
        n_rank     = r_rank;
        n_ok       = r_ok;
        n_dec      = r_dec;
        n_lt       = r_lt;
        n_gt       = r_gt;
        n_wr_end   = r_wr_end;
        n_cache_s  = r_cache_s;
        n_cache_e  = r_cache_e;
        n_cur_s    = r_cur_s;
        n_cur_e    = r_cur_e;
        n_res_s    = r_res_s;
        n_res_e    = r_res_e;
        n_res_dim  = r_res_dim;
        n_res_blk  = r_res_blk;
        n_res_last = r_res_last;
        n_res_proc = r_res_proc;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_start  = r_out_start;
        n_out_extent = r_out_extent;
        n_out_dim    = r_out_dim;
        n_out_blk    = r_out_blk;
        n_out_cnt    = r_out_cnt;
        n_out_last   = r_out_last;
        n_out_ovf    = r_out_ovf;

        unique case (r_state)
            blsc_pkg::S_IDLE: begin
                if (in_xfer) begin
                    case (i_func)
                        blsc_pkg::FUNC_LOAD: begin
                            if (r_n == CNT_W'(blsc_pkg::MAX_BLOCKS)) begin
                                n_ovf = 1'b1;
                            end else if (lpos == ndm1) begin
                                n_load_pos = '0;
                                n_n        = r_n + CNT_W'(1);
                            end else begin
                                n_load_pos = lpos + DIM_W'(1);
                            end
                        end
                        blsc_pkg::FUNC_PROC: begin
                            n_load_pos = '0;
                            n_phase    = r_premerge ? blsc_pkg::PH_PRE : blsc_pkg::PH_SORT;
                            n_d        = ndm1;
                            n_res_proc = 1'b1;
                        end
                        blsc_pkg::FUNC_READ: begin
                            if (rd_avail) begin
                                n_res_blk  = rd_blk;
                                n_res_dim  = rd_dim;
                                n_res_last = (TOT_W'(r_read_pos) + TOT_W'(1)) == total;
                                n_res_proc = 1'b0;
                                n_read_pos = r_read_pos + POS_W'(1);
                            end
                        end
                        default: begin
                            n_res_proc = r_res_proc;
                        end
                    endcase
                end
            end
            blsc_pkg::S_RD_DATA: begin
                n_res_s = rd_s;
                n_res_e = rd_e;
            end
            blsc_pkg::S_RESULT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = r_n;
                    n_out_ovf   = r_ovf;
                    if (r_res_proc) begin
                        n_out_start  = '0;
                        n_out_extent = '0;
                        n_out_dim    = '0;
                        n_out_blk    = '0;
                        n_out_last   = 1'b0;
                    end else begin
                        n_out_start  = r_res_s;
                        n_out_extent = r_res_e;
                        n_out_dim    = r_res_dim;
                        n_out_blk    = r_res_blk;
                        n_out_last   = r_res_last;
                    end
                end
            end
            // Merge pass: row j cached, row i streamed and tested
            blsc_pkg::S_MG_INIT: begin
                n_j = '0;
                n_k = '0;
            end
            blsc_pkg::S_MG_J_CAP: begin
                n_cache_s[r_k] = rd_s;
                n_cache_e[r_k] = rd_e;
                if (k_last) begin
                    n_k = '0;
                    n_i = CNT_W'(1);
                end else begin
                    n_k = r_k + DIM_W'(1);
                end
            end
            blsc_pkg::S_MG_I_CHK: begin
                n_ok     = 1'b1;
                n_k      = '0;
                n_wr_end = (r_i == r_n);
            end
            blsc_pkg::S_MG_I_CAP: begin
                n_cur_s[r_k] = rd_s;
                n_cur_e[r_k] = rd_e;
                n_ok         = r_ok && cond;
                n_k          = k_last ? '0 : r_k + DIM_W'(1);
            end
            blsc_pkg::S_MG_DECIDE: begin
                if (r_ok) begin
                    if (r_ext_end) begin
                        n_cache_e[r_d] = (jei > jce) ? jei : jce;
                    end else begin
                        n_cache_e[r_d] = msum[CW] ? '1 : msum[CW-1:0];
                    end
                    n_i = r_i + CNT_W'(1);
                end
                n_k = '0;
            end
            blsc_pkg::S_MG_WR: begin
                if (k_last) begin
                    n_k = '0;
                    if (r_wr_end) begin
                        n_n = r_j + CNT_W'(1);
                        if (r_d != '0) n_d = r_d - DIM_W'(1);
                    end else begin
                        n_j       = r_j + CNT_W'(1);
                        n_i       = r_i + CNT_W'(1);
                        n_cache_s = r_cur_s;
                        n_cache_e = r_cur_e;
                    end
                end else begin
                    n_k = r_k + DIM_W'(1);
                end
            end
            blsc_pkg::S_MG_END: begin
                if (r_phase == blsc_pkg::PH_PRE) begin
                    n_phase = blsc_pkg::PH_SORT;
                end else begin
                    n_read_pos = '0;
                end
            end
            // Stable sort by rank count into the other bank
            blsc_pkg::S_SR_INIT: begin
                n_i = '0;
                n_k = '0;
                if (r_n <= CNT_W'(1)) begin
                    n_phase = blsc_pkg::PH_POST;
                    n_d     = ndm1;
                end
            end
            blsc_pkg::S_SR_I_CAP: begin
                n_cache_s[r_k] = rd_s;
                n_cache_e[r_k] = rd_e;
                if (k_last) begin
                    n_k    = '0;
                    n_j    = '0;
                    n_rank = '0;
                end else begin
                    n_k = r_k + DIM_W'(1);
                end
            end
            blsc_pkg::S_SR_J_CHK: begin
                n_k   = '0;
                n_dec = 1'b0;
                n_lt  = 1'b0;
                n_gt  = 1'b0;
                if ((r_j != r_n) && (r_j == r_i)) n_j = r_j + CNT_W'(1);
            end
            blsc_pkg::S_SR_J_CAP: begin
                if (!r_dec) begin
                    if (rd_s < r_cache_s[r_k]) begin
                        n_lt  = 1'b1;
                        n_dec = 1'b1;
                    end else if (r_cache_s[r_k] < rd_s) begin
                        n_gt  = 1'b1;
                        n_dec = 1'b1;
                    end
                end
                n_k = k_last ? '0 : r_k + DIM_W'(1);
            end
            blsc_pkg::S_SR_J_EVAL: begin
                if ((r_j < r_i) ? !r_gt : r_lt) n_rank = r_rank + BLK_W'(1);
                n_j = r_j + CNT_W'(1);
            end
            blsc_pkg::S_SR_WR: begin
                if (k_last) begin
                    n_k = '0;
                    n_i = r_i + CNT_W'(1);
                    if ((r_i + CNT_W'(1)) == r_n) begin
                        n_bank  = ~r_bank;
                        n_phase = blsc_pkg::PH_POST;
                        n_d     = ndm1;
                    end
                end else begin
                    n_k = r_k + DIM_W'(1);
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= blsc_pkg::S_IDLE;
            r_phase     <= blsc_pkg::PH_SORT;
            r_n         <= '0;
            r_load_pos  <= '0;
            r_read_pos  <= '0;
            r_ovf       <= 1'b0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_n         <= n_n;
            r_load_pos  <= n_load_pos;
            r_read_pos  <= n_read_pos;
            r_ovf       <= n_ovf;
            r_bank      <= n_bank;
            r_out_valid <= n_out_valid;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= NDIM_W'(1);
            r_ext_end  <= 1'b0;
            r_premerge <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                blsc_pkg::CFG_NUM_DIMS: r_num_dims <= i_cfg_data;
                blsc_pkg::CFG_EXT_END:  r_ext_end  <= i_cfg_data[0];
                blsc_pkg::CFG_PREMERGE: r_premerge <= i_cfg_data[0];
                default:                r_premerge <= r_premerge;
            endcase
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_d          <= n_d;
        r_k          <= n_k;
        r_i          <= n_i;
        r_j          <= n_j;
        r_rank       <= n_rank;
        r_ok         <= n_ok;
        r_dec        <= n_dec;
        r_lt         <= n_lt;
        r_gt         <= n_gt;
        r_wr_end     <= n_wr_end;
        r_cache_s    <= n_cache_s;
        r_cache_e    <= n_cache_e;
        r_cur_s      <= n_cur_s;
        r_cur_e      <= n_cur_e;
        r_res_s      <= n_res_s;
        r_res_e      <= n_res_e;
        r_res_dim    <= n_res_dim;
        r_res_blk    <= n_res_blk;
        r_res_last   <= n_res_last;
        r_res_proc   <= n_res_proc;
        r_out_start  <= n_out_start;
        r_out_extent <= n_out_extent;
        r_out_dim    <= n_out_dim;
        r_out_blk    <= n_out_blk;
        r_out_cnt    <= n_out_cnt;
        r_out_last   <= n_out_last;
        r_out_ovf    <= n_out_ovf;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_start   = r_out_start;
    assign o_out_extent  = r_out_extent;
    assign o_dim_index   = r_out_dim;
    assign o_block_index = r_out_blk;
    assign o_block_count = r_out_cnt;
    assign o_last_flag   = r_out_last;
    assign o_overflow    = r_out_ovf;

endmodule

/* rtl/blsc_checker.sv */
module blsc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_func,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_out_start,
    input logic [7:0]  o_block_index,
    input logic [8:0]  o_block_count,
    input logic        o_last_flag
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_start))
        else $error("result changed while stalled");

    // No result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Last coordinate belongs to the last block
    a_last_blk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_flag |-> ({1'b0, o_block_index} + 9'd1) == o_block_count)
        else $error("last flag on wrong block");

    // Nonzero block number stays below the count
    a_blk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_block_index != 8'd0) |-> {1'b0, o_block_index} < o_block_count)
        else $error("block index beyond count");

    // A process transfer starts work that holds off the next item
    a_proc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_func == 2'd1) |=> !o_in_ready)
        else $error("input taken during process");

endmodule

bind block_list_sort_and_coalesce blsc_checker u_blsc_checker (.*);
